[design/assert_macros.svh]
// Assertion macros for the complex rotate block checkers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, muted while reset is asserted
`define CRSS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// clocked check that stays live through reset
`define CRSS_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[design/crss_pkg.sv]
// Shared types and constants for the complex rotate, shift and saturate block
`default_nettype none

package crss_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_GAIN_REAL     = 2'd0;
    localparam logic [1:0] CFG_GAIN_IMAG     = 2'd1;
    localparam logic [1:0] CFG_SHIFT_AMOUNT  = 2'd2;
    localparam logic [1:0] CFG_ROUNDING_MODE = 2'd3;

    localparam logic        MODE_SHIFT = 1'b0;
    localparam logic        MODE_Q15   = 1'b1;

    localparam logic signed [15:0] GAIN_REAL_RST = 16'sh7FFF;
    localparam logic signed [15:0] GAIN_IMAG_RST = 16'sh0000;
    localparam logic [4:0]         SHIFT_RST     = 5'd15;

    localparam logic signed [15:0] Q15_MAX = 16'sh7FFF;
    localparam logic signed [15:0] Q15_MIN = -16'sh8000;

    typedef struct packed {
        logic signed [15:0] gain_real;
        logic signed [15:0] gain_imag;
        logic [4:0]         shift_amount;
        logic               rounding_mode;
    } t_cfg;

    // the four partial products of one word
    typedef struct packed {
        logic signed [31:0] p_rr;  // xr * gr
        logic signed [31:0] p_ii;  // xi * gi
        logic signed [31:0] p_ri;  // xr * gi
        logic signed [31:0] p_ir;  // xi * gr
        logic               last;
    } t_prod;

endpackage

`default_nettype wire

[design/crss_mult.sv]
// Product stage: four 16x16 signed multiplies into a register
`default_nettype none

module crss_mult
    import crss_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_en,
    input  wire logic               i_valid,
    input  wire logic signed [15:0] i_xr,
    input  wire logic signed [15:0] i_xi,
    input  wire logic               i_last,
    input  wire t_cfg               i_cfg,
    output logic                    o_valid,
    output t_prod                   o_prod
);

    logic  r_valid;
    t_prod r_prod;
    t_prod n_prod;

    always_comb begin
        n_prod.p_rr = i_xr * i_cfg.gain_real;
        n_prod.p_ii = i_xi * i_cfg.gain_imag;
        n_prod.p_ri = i_xr * i_cfg.gain_imag;
        n_prod.p_ir = i_xi * i_cfg.gain_real;
        n_prod.last = i_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
        end
    end

    assign o_valid = r_valid;
    assign o_prod  = r_prod;

endmodule

`default_nettype wire

[design/crss_post.sv]
// Result stage: combine products, shift or Q15 round, clamp to 16 bits
`default_nettype none

module crss_post
    import crss_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_en,
    input  wire logic        i_valid,
    input  wire t_prod       i_prod,
    input  wire t_cfg        i_cfg,
    output logic             o_valid,
    output logic signed [15:0] o_real,
    output logic signed [15:0] o_imag,
    output logic             o_last
);

    // doubling with 32-bit saturation; only +2^30 can overflow
    function automatic logic signed [31:0] dbl_sat(input logic signed [31:0] p);
        logic signed [31:0] d;
        begin
            if (p == 32'sh4000_0000) begin
                d = 32'sh7FFF_FFFF;
            end else begin
                d = p <<< 1;
            end
            return d;
        end
    endfunction

    function automatic logic signed [15:0] clamp16(input logic signed [32:0] v);
        logic signed [15:0] c;
        begin
            if (v > 33'(Q15_MAX)) begin
                c = Q15_MAX;
            end else if (v < 33'(Q15_MIN)) begin
                c = Q15_MIN;
            end else begin
                c = v[15:0];
            end
            return c;
        end
    endfunction

    localparam logic signed [32:0] HALF_LSB = 33'sd32768;

    logic signed [32:0] sum_re;
    logic signed [32:0] sum_im;
    logic signed [32:0] sh_re;
    logic signed [32:0] sh_im;
    logic signed [31:0] d_rr;
    logic signed [31:0] d_ii;
    logic signed [31:0] d_ri;
    logic signed [31:0] d_ir;
    logic signed [32:0] rnd_ii;
    logic signed [32:0] rnd_ri;
    logic signed [17:0] q_re;
    logic signed [17:0] q_im;
    logic signed [15:0] n_real;
    logic signed [15:0] n_imag;

    logic               r_valid;
    logic signed [15:0] r_real;
    logic signed [15:0] r_imag;
    logic               r_last;

    always_comb begin
        // generic path: exact wide sums, arithmetic shift
        sum_re = 33'(i_prod.p_rr) - 33'(i_prod.p_ii);
        sum_im = 33'(i_prod.p_ri) + 33'(i_prod.p_ir);
        sh_re  = sum_re >>> i_cfg.shift_amount;
        sh_im  = sum_im >>> i_cfg.shift_amount;

        // Q15 path: doubled, saturated, high half, rounding on two terms
        d_rr   = dbl_sat(i_prod.p_rr);
        d_ii   = dbl_sat(i_prod.p_ii);
        d_ri   = dbl_sat(i_prod.p_ri);
        d_ir   = dbl_sat(i_prod.p_ir);
        rnd_ii = 33'(d_ii) + HALF_LSB;
        rnd_ri = 33'(d_ri) + HALF_LSB;
        // high halves are signed; extend them as such
        q_re   = 18'($signed(d_rr[31:16])) - 18'($signed(rnd_ii[32:16]));
        q_im   = 18'($signed(rnd_ri[32:16])) + 18'($signed(d_ir[31:16]));

        if (i_cfg.rounding_mode == MODE_Q15) begin
            n_real = clamp16(33'(q_re));
            n_imag = clamp16(33'(q_im));
        end else begin
            n_real = clamp16(sh_re);
            n_imag = clamp16(sh_im);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_real <= n_real;
            r_imag <= n_imag;
            r_last <= i_prod.last;
        end
    end

    assign o_valid = r_valid;
    assign o_real  = r_real;
    assign o_imag  = r_imag;
    assign o_last  = r_last;

endmodule

`default_nettype wire

[design/complex_rotate_shift_saturate_top.sv]
// Top level: complex gain multiply with shift or Q15 rounding and saturation
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+----------------------------------
//  in      | sink      | i_in_valid / o_in_ready | i_sample_real/imag (s16), _last
//  out     | source    | o_out_valid/i_out_ready | o_out_real/imag (s16), o_out_last
//  cfg     | sink      | i_cfg_we (no wait)      | i_cfg_addr (2b), i_cfg_data (16b)
//
// One word per cycle sustained if i_out_ready holds. Three registers: input, product
// (four 16x16 multipliers), result (sum, shift or round, clamp), in that order.
// A stage loads when the next is empty or handing on, so bubbles close up; with all
// three full, o_in_ready follows i_out_ready.
// Reset (synchronous, active low) empties the pipe; gain 0x7FFF, shift 15, shift path.
// The user writes config only with the pipe empty (not checked); both stages read it live.
`default_nettype none

module complex_rotate_shift_saturate_top
    import crss_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // input words
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic signed [15:0] i_sample_real,
    input  wire logic signed [15:0] i_sample_imag,
    input  wire logic               i_sample_last,
    // result words
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic signed [15:0]      o_out_real,
    output logic signed [15:0]      o_out_imag,
    output logic                    o_out_last,
    // config write port
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_addr,
    input  wire logic [15:0]        i_cfg_data
);

    // config registers
    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_real     <= GAIN_REAL_RST;
            r_cfg.gain_imag     <= GAIN_IMAG_RST;
            r_cfg.shift_amount  <= SHIFT_RST;
            r_cfg.rounding_mode <= MODE_SHIFT;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_GAIN_REAL:     r_cfg.gain_real     <= i_cfg_data;
                CFG_GAIN_IMAG:     r_cfg.gain_imag     <= i_cfg_data;
                CFG_SHIFT_AMOUNT:  r_cfg.shift_amount  <= i_cfg_data[4:0];
                CFG_ROUNDING_MODE: r_cfg.rounding_mode <= i_cfg_data[0];
                default:           ;
            endcase
        end
    end

    // stage enables: a stage loads when its successor is free or moving
    logic  prod_valid;
    logic  out_valid;
    logic  en_out;
    logic  en_prod;
    logic  en_in;

    logic               r_in_valid;
    logic signed [15:0] r_in_real;
    logic signed [15:0] r_in_imag;
    logic               r_in_last;

    t_prod prod;

    assign en_out     = !out_valid  || i_out_ready;
    assign en_prod    = !prod_valid || en_out;
    assign en_in      = !r_in_valid || en_prod;
    assign o_in_ready = en_in;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (en_in) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_in) begin
            r_in_real <= i_sample_real;
            r_in_imag <= i_sample_imag;
            r_in_last <= i_sample_last;
        end
    end

    crss_mult u_mult (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en_prod),
        .i_valid (r_in_valid),
        .i_xr    (r_in_real),
        .i_xi    (r_in_imag),
        .i_last  (r_in_last),
        .i_cfg   (r_cfg),
        .o_valid (prod_valid),
        .o_prod  (prod)
    );

    crss_post u_post (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en_out),
        .i_valid (prod_valid),
        .i_prod  (prod),
        .i_cfg   (r_cfg),
        .o_valid (out_valid),
        .o_real  (o_out_real),
        .o_imag  (o_out_imag),
        .o_last  (o_out_last)
    );

    assign o_out_valid = out_valid;

endmodule

`default_nettype wire

[design/crss_checker.sv]
// Port-level checker for the complex rotate block, bound to the top level
`default_nettype none

`include "assert_macros.svh"

module crss_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_ready,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic [15:0] o_out_real,
    input wire logic [15:0] o_out_imag,
    input wire logic        o_out_last
);

    // reset empties the pipe
    `CRSS_ASSERT_RST(a_rst_empty, !i_rst_n |=> !o_out_valid, "output valid after reset")

    // a stalled result holds
    `CRSS_ASSERT(a_out_hold,
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_real)
            && $stable(o_out_imag) && $stable(o_out_last),
        "stalled result word changed")

    // a full pipe under stall stays full; input ready then only follows the sink
    `CRSS_ASSERT(a_full_stays,
        o_out_valid && !i_out_ready && !o_in_ready |=> o_in_ready == i_out_ready,
        "input taken while pipe full and stalled")

    // an accepted word reaches the output when the sink keeps pulling
    `CRSS_ASSERT(a_latency,
        (i_in_valid && o_in_ready) ##1 i_out_ready ##1 i_out_ready |=> o_out_valid,
        "accepted word did not reach the output in three cycles")

endmodule

bind complex_rotate_shift_saturate_top crss_checker u_crss_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_real  (o_out_real),
    .o_out_imag  (o_out_imag),
    .o_out_last  (o_out_last)
);

`default_nettype wire
